FILE: design/mpq_pkg.sv
// Package: shared types, codes and sizes for the min-priority queue.
`default_nettype none
package mpq_pkg;

	localparam int DEPTH      = 64;
	localparam int TAG_BITS   = 16;
	localparam int PRIO_BITS  = 16;
	localparam int STAMP_BITS = 32;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_INSERT   = 2'd0,
		REQ_REMOVE   = 2'd1,
		REQ_DECREASE = 2'd2,
		REQ_CLEAR    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_EMPTY       = 3'd1,
		ST_NOT_FOUND   = 3'd2,
		ST_LESS_URGENT = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef struct packed {
		req_type_t              req_type;
		logic [TAG_BITS-1:0]    tag;
		logic [PRIO_BITS-1:0]   priority_req;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [TAG_BITS-1:0]    removed_tag;
		logic [PRIO_BITS-1:0]   removed_priority;
		logic                   front_valid;
		logic [TAG_BITS-1:0]    front_tag;
		logic [PRIO_BITS-1:0]   front_priority;
		logic [CNT_BITS-1:0]    occupancy;
	} result_t;

	// one slot as held in the entry memory
	typedef struct packed {
		logic [STAMP_BITS-1:0]  stamp;
		logic [PRIO_BITS-1:0]   prio;
		logic [TAG_BITS-1:0]    tag;
	} entry_t;

	// what one pass over the memory found
	typedef struct packed {
		logic                   front_found;
		logic [IDX_BITS-1:0]    front_idx;
		logic [TAG_BITS-1:0]    front_tag;
		logic [PRIO_BITS-1:0]   front_prio;
		logic                   match_found;
		logic [IDX_BITS-1:0]    match_idx;
		logic [PRIO_BITS-1:0]   match_prio;
		logic [STAMP_BITS-1:0]  match_stamp;
		logic                   free_found;
		logic [IDX_BITS-1:0]    free_idx;
	} scan_res_t;

endpackage
`default_nettype wire

FILE: design/min_priority_queue_fifo_ties_core.sv
// Top level: request sequencer, slot valid bits and counters around the entry memory.
`default_nettype none
// Min-priority queue of DEPTH slots held in one synchronous RAM. A request is
// taken when start is high and busy is low; busy then stays high until the
// result appears. Every request (insert, remove, decrease, clear) goes
// through the same steps from transfer to result: one pass over the RAM at
// one slot per cycle finds the free slot, the front and the matching tag, an
// apply step writes back, a second pass finds the new front, and a response
// step registers the result. done is high for exactly one cycle with the
// result on the result port; it is not held, so the receiver must take it
// then. A new request may be given in the same cycle that done is high.
module min_priority_queue_fifo_ties_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mpq_pkg::req_t    req,
	output logic                  busy,
	output logic                  done,
	output mpq_pkg::result_t      result
);
	import mpq_pkg::*;

	typedef enum logic [2:0] {
		IDLE, S1_RD, S1_END, APPLY, S2_RD, S2_END, RESP
	} state_t;

	state_t                state_q;
	req_t                  req_q;
	logic [IDX_BITS-1:0]   addr_q;
	logic                  rd_vld_s1;
	logic [IDX_BITS-1:0]   rd_idx_s1;
	logic [DEPTH-1:0]      valid_q;
	logic [STAMP_BITS-1:0] arrival_q;
	logic [CNT_BITS-1:0]   count_q;
	status_t               status_q;
	logic [TAG_BITS-1:0]   rtag_q;
	logic [PRIO_BITS-1:0]  rprio_q;
	result_t               result_q;
	logic                  done_q;

	logic       rd_en, scan_clr, wr_en;
	entry_t     rd_data, wr_data;
	logic [IDX_BITS-1:0] wr_addr;
	scan_res_t  scan;
	logic       accept;
	logic       rm_hit;

	assign accept   = start && (state_q == IDLE);
	assign rd_en    = (state_q == S1_RD) || (state_q == S2_RD);
	assign scan_clr = accept || (state_q == APPLY);
	assign rm_hit   = (req_q.req_type == REQ_REMOVE) && scan.front_found;

	mpq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	mpq_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (scan_clr),
		.hit        (rd_vld_s1),
		.idx        (rd_idx_s1),
		.slot_valid (valid_q[rd_idx_s1]),
		.slot       (rd_data),
		.key_tag    (req_q.tag),
		.res        (scan)
	);

	// write-back of the request's slot, taken in the apply cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan.free_idx;
		wr_data = '{stamp: arrival_q + 1'b1, prio: req_q.priority_req, tag: req_q.tag};
		if (state_q == APPLY) begin
			unique case (req_q.req_type)
				REQ_INSERT: begin
					wr_en = scan.free_found;
				end
				REQ_DECREASE: begin
					wr_en   = scan.match_found && !(scan.match_prio < req_q.priority_req);
					wr_addr = scan.match_idx;
					wr_data = '{stamp: scan.match_stamp, prio: req_q.priority_req,
						tag: req_q.tag};
				end
				REQ_REMOVE, REQ_CLEAR: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			arrival_q <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			done_q    <= (state_q == RESP);
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= S1_RD;
						addr_q  <= '0;
					end
				end
				S1_RD, S2_RD: begin
					if (addr_q == IDX_BITS'(DEPTH - 1)) begin
						addr_q  <= '0;
						state_q <= (state_q == S1_RD) ? S1_END : S2_END;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S1_END: begin
					state_q <= APPLY;
				end
				APPLY: begin
					state_q <= S2_RD;
					unique case (req_q.req_type)
						REQ_INSERT: begin
							if (scan.free_found) begin
								valid_q[scan.free_idx] <= 1'b1;
								arrival_q <= arrival_q + 1'b1;
								count_q   <= count_q + 1'b1;
							end
						end
						REQ_REMOVE: begin
							if (scan.front_found) begin
								valid_q[scan.front_idx] <= 1'b0;
								count_q <= count_q - 1'b1;
							end
						end
						REQ_DECREASE: begin
						end
						REQ_CLEAR: begin
							valid_q <= '0;
							count_q <= '0;
						end
					endcase
				end
				S2_END: begin
					state_q <= RESP;
				end
				RESP: begin
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			req_q <= req;
		end
		if (state_q == APPLY) begin
			rtag_q  <= rm_hit ? scan.front_tag : '0;
			rprio_q <= rm_hit ? scan.front_prio : '0;
			unique case (req_q.req_type)
				REQ_INSERT: begin
					if (!scan.free_found) status_q <= ST_FULL;
					else status_q <= ST_OK;
				end
				REQ_REMOVE: begin
					if (!scan.front_found) status_q <= ST_EMPTY;
					else status_q <= ST_OK;
				end
				REQ_DECREASE: begin
					if (!scan.match_found) begin
						status_q <= ST_NOT_FOUND;
					end else if (scan.match_prio < req_q.priority_req) begin
						status_q <= ST_LESS_URGENT;
					end else begin
						status_q <= ST_OK;
					end
				end
				REQ_CLEAR: begin
					status_q <= ST_OK;
				end
			endcase
		end
		if (state_q == RESP) begin
			result_q.status           <= status_q;
			result_q.removed_tag      <= rtag_q;
			result_q.removed_priority <= rprio_q;
			result_q.front_valid      <= scan.front_found;
			result_q.front_tag        <= scan.front_found ? scan.front_tag : '0;
			result_q.front_priority   <= scan.front_found ? scan.front_prio : '0;
			result_q.occupancy        <= count_q;
		end
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

FILE: design/mpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: design/mpq_scan.sv
// Scan unit: folds one returned slot per cycle into front, tag match and first free slot.
`default_nettype none
module mpq_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          clr,
	input  wire logic                          hit,
	input  wire logic [mpq_pkg::IDX_BITS-1:0]  idx,
	input  wire logic                          slot_valid,
	input  wire mpq_pkg::entry_t               slot,
	input  wire logic [mpq_pkg::TAG_BITS-1:0]  key_tag,
	output mpq_pkg::scan_res_t                 res
);
	import mpq_pkg::*;

	logic                  front_found_q, match_found_q, free_found_q;
	logic [IDX_BITS-1:0]   front_idx_q, match_idx_q, free_idx_q;
	logic [TAG_BITS-1:0]   front_tag_q;
	logic [PRIO_BITS-1:0]  front_prio_q, match_prio_q;
	logic [STAMP_BITS-1:0] front_stamp_q, match_stamp_q;

	logic take_front, take_match, take_free;

	// strict compares: on a full tie the lower slot index stays
	always_comb begin
		take_front = hit && slot_valid &&
			(!front_found_q || (slot.prio < front_prio_q) ||
			 ((slot.prio == front_prio_q) && (slot.stamp < front_stamp_q)));
		take_match = hit && slot_valid && (slot.tag == key_tag) &&
			(!match_found_q || (slot.stamp < match_stamp_q));
		take_free  = hit && !slot_valid && !free_found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_found_q <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (clr) begin
			front_found_q <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			if (take_front) front_found_q <= 1'b1;
			if (take_match) match_found_q <= 1'b1;
			if (take_free)  free_found_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && take_front) begin
			front_idx_q   <= idx;
			front_tag_q   <= slot.tag;
			front_prio_q  <= slot.prio;
			front_stamp_q <= slot.stamp;
		end
		if (!clr && take_match) begin
			match_idx_q   <= idx;
			match_prio_q  <= slot.prio;
			match_stamp_q <= slot.stamp;
		end
		if (!clr && take_free) begin
			free_idx_q <= idx;
		end
	end

	always_comb begin
		res.front_found = front_found_q;
		res.front_idx   = front_idx_q;
		res.front_tag   = front_tag_q;
		res.front_prio  = front_prio_q;
		res.match_found = match_found_q;
		res.match_idx   = match_idx_q;
		res.match_prio  = match_prio_q;
		res.match_stamp = match_stamp_q;
		res.free_found  = free_found_q;
		res.free_idx    = free_idx_q;
	end

endmodule
`default_nettype wire

FILE: design/mpq_checker.sv
// Port-level checker for the queue core, bound to the top level.
`default_nettype none
module mpq_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic             done,
	input  wire mpq_pkg::result_t result
);
	import mpq_pkg::*;

	// a transfer always starts a request that holds busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request transfer");

	// a result only shows once the request has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe while busy or without a request");

	a_front_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.front_valid == (result.occupancy != '0)))
		else $error("front_valid disagrees with occupancy");

	a_front_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.front_valid) |->
			(result.front_tag == '0 && result.front_priority == '0))
		else $error("front fields not zero on empty queue");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |->
			(result.removed_tag == '0 && result.removed_priority == '0))
		else $error("removed fields set on failed request");

endmodule

bind min_priority_queue_fifo_ties_core mpq_checker u_mpq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
